// ===== rtl/ascc_pkg.sv =====
// Shared types, codes and constants of the credential checker.
package ascc_pkg;

    localparam int MAX_GROUPS_DEF     = 16;
    localparam int MAX_BLOB_BYTES_DEF = 512;
    localparam int MIN_SYS_BYTES      = 20;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 32;

    localparam logic [31:0] ID_LIMIT     = 32'd65535;
    localparam logic [31:0] ANON_DEFAULT = 32'd65534;
    localparam logic [31:0] WORD_BYTES   = 32'd4;
    localparam logic [31:0] PAD_MASK     = 32'd3;

    localparam logic [7:0] FLAVOR_NONE = 8'd1;
    localparam logic [7:0] FLAVOR_SYS  = 8'd2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_FLAVOR  = 3'd0,
        PH_STAMP   = 3'd1,
        PH_NAMELEN = 3'd2,
        PH_SKIP    = 3'd3,
        PH_UID     = 3'd4,
        PH_GID     = 3'd5,
        PH_COUNT   = 3'd6,
        PH_GIDS    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_HEAD = 2'd1,
        EM_LIST = 2'd2
    } t_emit_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_SQUASH = 2'd0,
        CFG_ALL_SQUASH  = 2'd1,
        CFG_ANON_UID    = 2'd2,
        CFG_ANON_GID    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        root_squash;
        logic        all_squash;
        logic [31:0] anon_uid;
        logic [31:0] anon_gid;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        flavor_sys;
        logic        squash;
        logic        trunc;
        logic [31:0] uid;
        logic [31:0] gid;
        logic [31:0] name_len;
    } t_summary;

endpackage

// ===== rtl/ascc_if.sv =====
// Valid/ready channel interfaces for credential bytes and result beats.
interface ascc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cred_byte;
    logic       byte_present;
    logic       final_byte;

    modport source (output valid, cred_byte, byte_present, final_byte, input ready);
    modport sink   (input valid, cred_byte, byte_present, final_byte, output ready);
endinterface

interface ascc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        flavor_sys;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic        is_list_item;
    logic [31:0] name_length;
    logic        groups_truncated;
    logic        last_result;

    modport source (output valid, status, flavor_sys, user_id, group_id, is_list_item,
                    name_length, groups_truncated, last_result, input ready);
    modport sink   (input valid, status, flavor_sys, user_id, group_id, is_list_item,
                    name_length, groups_truncated, last_result, output ready);
endinterface

// ===== rtl/ascc_gstore.sv =====
// Supplementary group store: one write port, one registered read port.
module ascc_gstore import ascc_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_we,
    input  logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] i_waddr,
    input  logic [31:0]                                           i_wdata,
    input  logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] i_raddr,
    output logic [31:0]                                           o_rdata
);

    logic [31:0] r_mem [MAX_GROUPS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ascc_parse.sv =====
// Byte-wise credential parser that fills the group store and builds the blob summary.
module ascc_parse import ascc_pkg::*; #(
    parameter int MAX_GROUPS     = MAX_GROUPS_DEF,
    parameter int MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_take,
    input  logic [7:0]                                            i_byte,
    input  logic                                                  i_present,
    input  logic                                                  i_final,
    input  t_cfg                                                  i_cfg,
    output logic                                                  o_mem_we,
    output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] o_mem_addr,
    output logic [31:0]                                           o_mem_data,
    output logic                                                  o_done,
    output t_summary                                              o_sum,
    output logic [$clog2(MAX_GROUPS + 2)-1:0]                     o_cnt
);

    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 2);
    localparam int OW = $clog2(MAX_BLOB_BYTES + 2);
    localparam logic [OW-1:0] OFF_MAX  = OW'(MAX_BLOB_BYTES);
    localparam logic [OW-1:0] OFF_MIN  = OW'(MIN_SYS_BYTES);
    localparam logic [CW-1:0] SEEN_MAX = CW'(MAX_GROUPS);

    logic [OW-1:0] r_offset, n_offset;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_flavor, n_flavor;
    logic [31:0]   r_shift, n_shift;
    logic [31:0]   r_name_len, n_name_len;
    logic [31:0]   r_skip, n_skip;
    logic [31:0]   r_uid, n_uid;
    logic [31:0]   r_gid, n_gid;
    logic [31:0]   r_claimed, n_claimed;
    logic [CW-1:0] r_seen, n_seen;
    logic [1:0]    r_fail, n_fail;
    logic          r_done, n_done;
    t_summary      r_sum, n_sum;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [31:0]   word;
    logic [31:0]   skip_dec;
    logic          bad;
    logic          squash;
    logic          trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_phase    <= PH_FLAVOR;
            r_flavor   <= '0;
            r_shift    <= '0;
            r_name_len <= '0;
            r_skip     <= '0;
            r_uid      <= '0;
            r_gid      <= '0;
            r_claimed  <= '0;
            r_seen     <= '0;
            r_fail     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_offset   <= n_offset;
            r_phase    <= n_phase;
            r_flavor   <= n_flavor;
            r_shift    <= n_shift;
            r_name_len <= n_name_len;
            r_skip     <= n_skip;
            r_uid      <= n_uid;
            r_gid      <= n_gid;
            r_claimed  <= n_claimed;
            r_seen     <= n_seen;
            r_fail     <= n_fail;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_offset   = r_offset;
        n_phase    = r_phase;
        n_flavor   = r_flavor;
        n_shift    = r_shift;
        n_name_len = r_name_len;
        n_skip     = r_skip;
        n_uid      = r_uid;
        n_gid      = r_gid;
        n_claimed  = r_claimed;
        n_seen     = r_seen;
        n_fail     = r_fail;
        n_done     = 1'b0;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        o_mem_we   = 1'b0;
        word       = {r_shift[23:0], i_byte};
        skip_dec   = (r_skip != '0) ? r_skip - 32'd1 : r_skip;
        bad        = 1'b0;
        squash     = 1'b0;
        trunc      = 1'b0;

        if (i_take && i_present) begin
            if (r_offset >= OFF_MAX) begin
                n_offset  = OFF_MAX + OW'(1);
                n_fail[1] = 1'b1;
            end else begin
                n_offset = r_offset + OW'(1);
                if (r_offset == '0) begin
                    n_flavor = i_byte;
                    if (i_byte == FLAVOR_SYS) begin
                        n_phase = PH_STAMP;
                        n_skip  = WORD_BYTES;
                        n_shift = '0;
                    end
                end else if (r_flavor == FLAVOR_SYS) begin
                    if (r_phase == PH_SKIP) begin
                        n_skip = skip_dec;
                        if (skip_dec == '0) begin
                            n_phase = PH_UID;
                            n_skip  = WORD_BYTES;
                            n_shift = '0;
                        end
                    end else if (!(r_phase == PH_GIDS && r_claimed == '0)) begin
                        n_shift = word;
                        n_skip  = skip_dec;
                        if (skip_dec == '0) begin
                            n_skip  = WORD_BYTES;
                            n_shift = '0;
                            unique case (r_phase)
                                PH_STAMP: begin
                                    n_phase = PH_NAMELEN;
                                end
                                PH_NAMELEN: begin
                                    // Name plus padding to a word boundary from the blob start.
                                    n_name_len = word;
                                    n_skip     = word | PAD_MASK;
                                    n_phase    = PH_SKIP;
                                end
                                PH_UID: begin
                                    n_uid   = word;
                                    n_phase = PH_GID;
                                end
                                PH_GID: begin
                                    n_gid   = word;
                                    n_phase = PH_COUNT;
                                end
                                PH_COUNT: begin
                                    n_claimed = word;
                                    n_phase   = PH_GIDS;
                                end
                                PH_GIDS: begin
                                    if (word > ID_LIMIT) begin
                                        n_fail[0] = 1'b1;
                                    end
                                    if (r_seen < SEEN_MAX) begin
                                        o_mem_we = 1'b1;
                                    end
                                    if (r_seen <= SEEN_MAX) begin
                                        n_seen = r_seen + CW'(1);
                                    end
                                    n_claimed = r_claimed - 32'd1;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
        end

        if (i_take && i_final) begin
            n_done = 1'b1;
            n_sum  = '{status: ST_INVALID, flavor_sys: 1'b0, squash: 1'b0, trunc: 1'b0,
                       uid: '0, gid: '0, name_len: '0};
            n_cnt  = '0;
            bad    = (n_fail != '0) || (n_offset < OFF_MIN) || (n_phase != PH_GIDS) ||
                     (n_name_len == '0) || (n_uid > ID_LIMIT) || (n_gid > ID_LIMIT);
            squash = i_cfg.all_squash || (i_cfg.root_squash && n_uid == '0);
            trunc  = n_seen > SEEN_MAX;
            if (n_offset == '0) begin
                n_sum.status = ST_INVALID;
            end else if (n_flavor == FLAVOR_NONE) begin
                n_sum.status = ST_OK;
            end else if (n_flavor != FLAVOR_SYS) begin
                n_sum.status = ST_UNSUPPORTED;
            end else if (bad) begin
                n_sum.flavor_sys = 1'b1;
            end else if (squash) begin
                n_sum = '{status: ST_OK, flavor_sys: 1'b1, squash: 1'b1, trunc: 1'b0,
                          uid: i_cfg.anon_uid, gid: i_cfg.anon_gid, name_len: n_name_len};
                n_cnt = CW'(1);
            end else begin
                n_sum = '{status: ST_OK, flavor_sys: 1'b1, squash: 1'b0, trunc: trunc,
                          uid: n_uid, gid: n_gid, name_len: n_name_len};
                n_cnt = trunc ? SEEN_MAX : n_seen;
            end

            n_offset   = '0;
            n_phase    = PH_FLAVOR;
            n_flavor   = '0;
            n_shift    = '0;
            n_name_len = '0;
            n_skip     = '0;
            n_uid      = '0;
            n_gid      = '0;
            n_claimed  = '0;
            n_seen     = '0;
            n_fail     = '0;
        end
    end

    assign o_mem_addr = r_seen[AW-1:0];
    assign o_mem_data = word;
    assign o_done     = r_done;
    assign o_sum      = r_sum;
    assign o_cnt      = r_cnt;

endmodule

// ===== rtl/ascc_emit.sv =====
// Result sequencer: head beat, then the group list read from the store.
module ascc_emit import ascc_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  t_summary                                              i_sum,
    input  logic [$clog2(MAX_GROUPS + 2)-1:0]                     i_cnt,
    input  logic [31:0]                                           i_rd_data,
    output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] o_rd_addr,
    output logic                                                  o_busy,
    ascc_out_if.source                                            o_res
);

    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 2);

    t_emit_state   r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_valid;
    logic [1:0]    r_status;
    logic          r_flavor_sys;
    logic [31:0]   r_user_id;
    logic [31:0]   r_group_id;
    logic          r_is_list;
    logic [31:0]   r_name_len;
    logic          r_trunc;
    logic          r_last;

    logic          out_free;
    logic          load;
    logic          load_list;
    logic          last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        load      = 1'b0;
        load_list = 1'b0;
        last      = 1'b0;
        out_free  = !r_valid || o_res.ready;
        unique case (r_state)
            EM_IDLE: begin
                if (i_start) begin
                    n_state = EM_HEAD;
                    n_idx   = '0;
                end
            end
            EM_HEAD: begin
                if (out_free) begin
                    load    = 1'b1;
                    last    = (i_cnt == '0);
                    n_state = last ? EM_IDLE : EM_LIST;
                end
            end
            EM_LIST: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_list = 1'b1;
                    last      = (r_idx + CW'(1) == i_cnt);
                    n_idx     = r_idx + CW'(1);
                    if (last) begin
                        n_state = EM_IDLE;
                    end
                end
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
    end

    // The read address runs one step ahead, so the store data matches r_idx in the list state.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status     <= i_sum.status;
            r_flavor_sys <= i_sum.flavor_sys;
            r_user_id    <= i_sum.uid;
            r_group_id   <= (load_list && !i_sum.squash) ? i_rd_data : i_sum.gid;
            r_is_list    <= load_list;
            r_name_len   <= i_sum.name_len;
            r_trunc      <= i_sum.trunc;
            r_last       <= last;
        end
    end

    assign o_rd_addr              = n_idx[AW-1:0];
    assign o_busy                 = (r_state != EM_IDLE);
    assign o_res.valid            = r_valid;
    assign o_res.status           = r_status;
    assign o_res.flavor_sys       = r_flavor_sys;
    assign o_res.user_id          = r_user_id;
    assign o_res.group_id         = r_group_id;
    assign o_res.is_list_item     = r_is_list;
    assign o_res.name_length      = r_name_len;
    assign o_res.groups_truncated = r_trunc;
    assign o_res.last_result      = r_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == EM_IDLE)
        else $error("Blob summary arrived while results were still being sent.");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == EM_LIST |-> r_idx < i_cnt)
        else $error("Group list index ran past the group count.");

    a_squash_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_sum.squash) |-> i_cnt == CW'(1))
        else $error("Squashed caller must carry exactly one group.");

    a_fail_no_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_sum.status != ST_OK) |-> i_cnt == '0)
        else $error("Failed blob must not carry a group list.");

endmodule

// ===== rtl/auth_sys_credential_checker.sv =====
// Top level of the credential checker: configuration registers, parser, group store, sequencer.
// Takes one credential byte beat per cycle while a blob is being parsed.
// The head result is loaded once the parser has registered the summary and the sequencer is in its
// head state with the output register free; list results follow one per cycle unless the output stalls.
// After the final beat, no input beat is taken until the last result is loaded.
// Synchronous reset restores the register defaults and the parser state; the store is not cleared.
module auth_sys_credential_checker import ascc_pkg::*; #(
    parameter int MAX_GROUPS     = MAX_GROUPS_DEF,
    parameter int MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    ascc_in_if.sink               i_cred,
    ascc_out_if.source            o_res
);

    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 2);

    t_cfg          r_cfg;
    logic          take;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          done;
    t_summary      sum;
    logic [CW-1:0] cnt;
    logic          emit_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{root_squash: 1'b1, all_squash: 1'b0,
                       anon_uid: ANON_DEFAULT, anon_gid: ANON_DEFAULT};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROOT_SQUASH: r_cfg.root_squash <= i_cfg_wdata[0];
                CFG_ALL_SQUASH:  r_cfg.all_squash  <= i_cfg_wdata[0];
                CFG_ANON_UID:    r_cfg.anon_uid    <= i_cfg_wdata[31:0];
                CFG_ANON_GID:    r_cfg.anon_gid    <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    assign i_cred.ready = !(emit_busy || done);
    assign take         = i_cred.valid && i_cred.ready;

    ascc_parse #(
        .MAX_GROUPS     (MAX_GROUPS),
        .MAX_BLOB_BYTES (MAX_BLOB_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_cred.cred_byte),
        .i_present  (i_cred.byte_present),
        .i_final    (i_cred.final_byte),
        .i_cfg      (r_cfg),
        .o_mem_we   (mem_we),
        .o_mem_addr (mem_waddr),
        .o_mem_data (mem_wdata),
        .o_done     (done),
        .o_sum      (sum),
        .o_cnt      (cnt)
    );

    ascc_gstore #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_gstore (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ascc_emit #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (done),
        .i_sum     (sum),
        .i_cnt     (cnt),
        .i_rd_data (mem_rdata),
        .o_rd_addr (mem_raddr),
        .o_busy    (emit_busy),
        .o_res     (o_res)
    );

endmodule
